FILE: sv/rmoa_pkg.sv
package rmoa_pkg;

  // Capacity of the digit stores
  localparam int MAX_DIGITS = 64;
  localparam int ADDR_W     = $clog2(MAX_DIGITS);
  localparam int LEN_W      = $clog2(MAX_DIGITS + 1);

  // Field widths
  localparam int CHAR_W  = 8;
  localparam int DIGIT_W = 6;
  localparam int RADIX_W = 6;

  // Column sum and carry: with digits below 36 the carry never exceeds 70
  localparam int SUM_W   = 8;
  localparam int CARRY_W = 7;

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam int                 RADIX_MIN   = 2;
  localparam int                 RADIX_MAX   = 36;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_A    = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_Z    = 8'h5A;
  localparam int                DEC_TEN   = 10;

  // Digit value given to a character that is not a digit at all
  localparam logic [DIGIT_W-1:0] DIGIT_NONE = '1;

  // Reciprocals for the carry: floor(s / b) == (s * RCP_TABLE[b]) >> RCP_SHIFT
  // for every column sum s below 2**SUM_W.
  localparam int RCP_SHIFT = 16;
  localparam int RCP_W     = 16;
  localparam int RCP_NUM   = (1 << RCP_SHIFT) - 1;

  localparam logic [RCP_W-1:0] RCP_TABLE [0:RADIX_MAX] = '{
    RCP_W'(0),              RCP_W'(0),              RCP_W'(RCP_NUM / 2 + 1),
    RCP_W'(RCP_NUM / 3 + 1),  RCP_W'(RCP_NUM / 4 + 1),  RCP_W'(RCP_NUM / 5 + 1),
    RCP_W'(RCP_NUM / 6 + 1),  RCP_W'(RCP_NUM / 7 + 1),  RCP_W'(RCP_NUM / 8 + 1),
    RCP_W'(RCP_NUM / 9 + 1),  RCP_W'(RCP_NUM / 10 + 1), RCP_W'(RCP_NUM / 11 + 1),
    RCP_W'(RCP_NUM / 12 + 1), RCP_W'(RCP_NUM / 13 + 1), RCP_W'(RCP_NUM / 14 + 1),
    RCP_W'(RCP_NUM / 15 + 1), RCP_W'(RCP_NUM / 16 + 1), RCP_W'(RCP_NUM / 17 + 1),
    RCP_W'(RCP_NUM / 18 + 1), RCP_W'(RCP_NUM / 19 + 1), RCP_W'(RCP_NUM / 20 + 1),
    RCP_W'(RCP_NUM / 21 + 1), RCP_W'(RCP_NUM / 22 + 1), RCP_W'(RCP_NUM / 23 + 1),
    RCP_W'(RCP_NUM / 24 + 1), RCP_W'(RCP_NUM / 25 + 1), RCP_W'(RCP_NUM / 26 + 1),
    RCP_W'(RCP_NUM / 27 + 1), RCP_W'(RCP_NUM / 28 + 1), RCP_W'(RCP_NUM / 29 + 1),
    RCP_W'(RCP_NUM / 30 + 1), RCP_W'(RCP_NUM / 31 + 1), RCP_W'(RCP_NUM / 32 + 1),
    RCP_W'(RCP_NUM / 33 + 1), RCP_W'(RCP_NUM / 34 + 1), RCP_W'(RCP_NUM / 35 + 1),
    RCP_W'(RCP_NUM / 36 + 1)
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_EMIT_READ,
    ST_EMIT_LOAD,
    ST_EMIT_HOLD
  } rmoa_state_t;

  // Controller to datapath
  typedef struct packed {
    logic take;
    logic acc_step;
    logic acc_fin;
    logic emit_next;
    logic emit_load;
    logic emit_done;
  } rmoa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_acc;
    logic set_end;
    logic eos_pend;
    logic acc_done;
    logic emit_last;
  } rmoa_sts_t;

  function automatic logic [DIGIT_W-1:0] char_value(input logic [CHAR_W-1:0] c);
    logic [DIGIT_W-1:0] v;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      v = DIGIT_W'(c - CHAR_ZERO);
    end else if (c >= CHAR_A && c <= CHAR_Z) begin
      v = DIGIT_W'(c - CHAR_A + CHAR_W'(DEC_TEN));
    end else begin
      v = DIGIT_NONE;
    end
    return v;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char_of(input logic [DIGIT_W-1:0] v);
    logic [CHAR_W-1:0] c;
    if (v < DIGIT_W'(DEC_TEN)) begin
      c = CHAR_ZERO + CHAR_W'(v);
    end else begin
      c = CHAR_A + CHAR_W'(v) - CHAR_W'(DEC_TEN);
    end
    return c;
  endfunction

endpackage

FILE: sv/rmoa_in_if.sv
interface rmoa_in_if import rmoa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] digit_char;
  logic              end_of_number;
  logic              end_of_set;

  modport source (output valid, digit_char, end_of_number, end_of_set, input ready);
  modport sink   (input valid, digit_char, end_of_number, end_of_set, output ready);
endinterface

FILE: sv/rmoa_out_if.sv
interface rmoa_out_if import rmoa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] sum_char;
  logic              last_char;
  logic              invalid_seen;
  logic              overflow;

  modport source (output valid, sum_char, last_char, invalid_seen, overflow, input ready);
  modport sink   (input valid, sum_char, last_char, invalid_seen, overflow, output ready);
endinterface

FILE: sv/rmoa_cfg_if.sv
interface rmoa_cfg_if import rmoa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RADIX_W-1:0] radix;

  modport source (output valid, radix, input ready);
  modport sink   (input valid, radix, output ready);
endinterface

FILE: sv/rmoa_ram.sv
module rmoa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/rmoa_ctrl.sv
module rmoa_ctrl import rmoa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  rmoa_sts_t sts,
  output rmoa_cmd_t cmd
);

  rmoa_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          priority if (sts.need_acc) state_nxt = ST_ACC;
          else if (sts.set_end)      state_nxt = ST_EMIT_READ;
          else                       state_nxt = ST_IDLE;
        end
      end
      ST_ACC: begin
        if (sts.acc_done) begin
          state_nxt = sts.eos_pend ? ST_EMIT_READ : ST_IDLE;
        end
      end
      ST_EMIT_READ: state_nxt = ST_EMIT_LOAD;
      ST_EMIT_LOAD: state_nxt = ST_EMIT_HOLD;
      ST_EMIT_HOLD: begin
        if (out_ready) begin
          state_nxt = sts.emit_last ? ST_IDLE : ST_EMIT_LOAD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_ACC: begin
        cmd.acc_step = !sts.acc_done;
        cmd.acc_fin  = sts.acc_done;
      end
      ST_EMIT_READ: ;
      ST_EMIT_LOAD: cmd.emit_load  = 1'b1;
      ST_EMIT_HOLD: begin
        out_valid     = 1'b1;
        cmd.emit_next = out_ready && !sts.emit_last;
        cmd.emit_done = out_ready && sts.emit_last;
      end
      default: ;
    endcase
  end

endmodule

FILE: sv/rmoa_dp.sv
module rmoa_dp import rmoa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  rmoa_cmd_t          cmd,
  output rmoa_sts_t          sts,
  input  logic               cfg_valid,
  input  logic [RADIX_W-1:0] cfg_radix,
  input  logic [CHAR_W-1:0]  digit_char,
  input  logic               end_of_number,
  input  logic               end_of_set,
  output logic [CHAR_W-1:0]  sum_char,
  output logic               last_char,
  output logic               invalid_seen,
  output logic               overflow
);

  logic [RADIX_W-1:0] radix_r;
  logic [RADIX_W-1:0] base;

  logic [LEN_W-1:0]  ilen_r, tlen_r, pcol_r, longest, icol;
  logic [ADDR_W-1:0] wp_r, wp_inc, rp_r, rp_src, irp, ek_r, wcol_r, t_raddr;
  logic              bad_r, inv_r, ovf_r, eos_r, pv_r, wv_r, last_r;

  logic [DIGIT_W-1:0] in_val, i_rdata, t_rdata, t_wdata;
  logic               in_ok, is_end, bad_now, full, cont;

  logic [CARRY_W-1:0]       carry_r, wq_r, q;
  logic [SUM_W-1:0]         a, b, sum, ws_r, rem;
  logic [SUM_W+RCP_W-1:0]   prod;
  logic [CARRY_W+RADIX_W-1:0] wprod;
  logic [CHAR_W-1:0]        sum_char_r;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_valid) begin
      radix_r <= cfg_radix;
    end
  end

  always_comb begin
    priority if (radix_r < RADIX_W'(RADIX_MIN)) base = RADIX_W'(RADIX_MIN);
    else if (radix_r > RADIX_W'(RADIX_MAX))     base = RADIX_W'(RADIX_MAX);
    else                                        base = radix_r;
  end

  // Digit intake
  assign in_val  = char_value(digit_char);
  assign in_ok   = in_val < base;
  assign is_end  = end_of_number || end_of_set;
  assign bad_now = bad_r || !in_ok;
  assign full    = ilen_r == LEN_W'(MAX_DIGITS);
  assign wp_inc  = (wp_r == ADDR_W'(MAX_DIGITS - 1)) ? '0 : wp_r + 1'b1;

  // Column walk: the incoming store is read backwards from the newest digit
  assign longest = (tlen_r > ilen_r) ? tlen_r : ilen_r;
  assign cont    = pv_r && (pcol_r < LEN_W'(MAX_DIGITS)) &&
                   ((pcol_r < longest) || (carry_r != '0));
  assign icol    = pv_r ? pcol_r + 1'b1 : '0;
  assign rp_src  = pv_r ? rp_r : wp_r;
  assign irp     = (rp_src == '0) ? ADDR_W'(MAX_DIGITS - 1) : rp_src - 1'b1;

  assign a    = (pcol_r < tlen_r) ? SUM_W'(t_rdata) : '0;
  assign b    = (pcol_r < ilen_r) ? SUM_W'(i_rdata) : '0;
  assign sum  = a + b + SUM_W'(carry_r);
  assign prod = {{RCP_W{1'b0}}, sum} * {{SUM_W{1'b0}}, RCP_TABLE[base]};
  assign q    = prod[RCP_SHIFT +: CARRY_W];

  // Remainder one stage later, off the carry loop
  assign wprod   = {{RADIX_W{1'b0}}, wq_r} * {{CARRY_W{1'b0}}, base};
  assign rem     = ws_r - wprod[SUM_W-1:0];
  assign t_wdata = DIGIT_W'(rem);

  always_comb begin
    priority if (cmd.acc_step) t_raddr = icol[ADDR_W-1:0];
    else if (cmd.emit_next)    t_raddr = ek_r - 1'b1;
    else                       t_raddr = ek_r;
  end

  rmoa_ram #(.WIDTH(DIGIT_W), .DEPTH(MAX_DIGITS)) u_in_ram (
    .clk   (clk),
    .we    (cmd.take && in_ok),
    .waddr (wp_r),
    .wdata (in_val),
    .raddr (irp),
    .rdata (i_rdata)
  );

  rmoa_ram #(.WIDTH(DIGIT_W), .DEPTH(MAX_DIGITS)) u_tot_ram (
    .clk   (clk),
    .we    (wv_r),
    .waddr (wcol_r),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ilen_r <= '0;
      wp_r   <= '0;
      bad_r  <= 1'b0;
      inv_r  <= 1'b0;
      ovf_r  <= 1'b0;
      tlen_r <= '0;
      eos_r  <= 1'b0;
      pv_r   <= 1'b0;
      wv_r   <= 1'b0;
    end else begin
      pv_r <= cmd.acc_step;
      wv_r <= cont;
      if (cmd.take) begin
        eos_r <= end_of_set;
        if (in_ok && full) ovf_r <= 1'b1;
        if (is_end && bad_now) begin
          // drop the whole number
          inv_r  <= 1'b1;
          ilen_r <= '0;
          wp_r   <= '0;
        end else if (in_ok) begin
          wp_r <= wp_inc;
          if (!full) ilen_r <= ilen_r + 1'b1;
        end
        if (is_end) begin
          bad_r <= 1'b0;
        end else if (!in_ok) begin
          bad_r <= 1'b1;
        end
      end
      if (cmd.acc_fin) begin
        tlen_r <= pcol_r;
        ilen_r <= '0;
        wp_r   <= '0;
        if (carry_r != '0) ovf_r <= 1'b1;
      end
      if (cmd.emit_done) begin
        tlen_r <= '0;
        inv_r  <= 1'b0;
        ovf_r  <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.acc_step) begin
      pcol_r <= icol;
      rp_r   <= irp;
      if (!pv_r) carry_r <= '0;
    end
    if (cont) begin
      carry_r <= q;
      ws_r    <= sum;
      wq_r    <= q;
      wcol_r  <= pcol_r[ADDR_W-1:0];
    end
    if (cmd.acc_fin) begin
      ek_r <= ADDR_W'(pcol_r - 1'b1);
    end
    if (cmd.emit_next) begin
      ek_r <= ek_r - 1'b1;
    end
    if (cmd.emit_load) begin
      sum_char_r <= (tlen_r == '0) ? CHAR_ZERO : digit_char_of(t_rdata);
      last_r     <= (tlen_r == '0) || (ek_r == '0);
    end
  end

  assign sts.need_acc  = is_end && !bad_now;
  assign sts.set_end   = end_of_set;
  assign sts.eos_pend  = eos_r;
  assign sts.acc_done  = pv_r && !cont;
  assign sts.emit_last = last_r;

  assign sum_char     = sum_char_r;
  assign last_char    = last_r;
  assign invalid_seen = inv_r;
  assign overflow     = ovf_r;

  a_rem_below_base: assert property (@(posedge clk) disable iff (!rst_n)
    wv_r |-> (rem < SUM_W'(base)))
    else $error("column remainder not below base");

  a_ilen_cap: assert property (@(posedge clk) disable iff (!rst_n)
    ilen_r <= LEN_W'(MAX_DIGITS))
    else $error("incoming length beyond capacity");

  a_tlen_cap: assert property (@(posedge clk) disable iff (!rst_n)
    tlen_r <= LEN_W'(MAX_DIGITS))
    else $error("total length beyond capacity");

  a_char_digit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_load |=> ((sum_char_r >= CHAR_ZERO && sum_char_r <= CHAR_NINE) ||
                       (sum_char_r >= CHAR_A && sum_char_r <= CHAR_Z)))
    else $error("emitted character is not a digit");

endmodule

FILE: sv/radix_multi_operand_adder.sv
// A number's closing digit holds off the input while the adder walks its columns,
// columns being the longer of total and number plus any final carry;
// the adder retires one column per cycle through the total store's read port.
// End of set: each sum character is read, then registered for output and held until taken.
// Reset: radix 10, lengths and flags cleared; digit stores need no clearing pass.
module radix_multi_operand_adder import rmoa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  rmoa_in_if.sink    in_ch,
  rmoa_out_if.source out_ch,
  rmoa_cfg_if.sink   cfg_ch
);

  rmoa_cmd_t cmd;
  rmoa_sts_t sts;

  // Radix writes are always taken; the user must send them only when idle (not enforced).
  assign cfg_ch.ready = 1'b1;

  // Sequence intake, column addition and emission of the total.
  rmoa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold the digit stores, the running total and the result register.
  rmoa_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_valid     (cfg_ch.valid),
    .cfg_radix     (cfg_ch.radix),
    .digit_char    (in_ch.digit_char),
    .end_of_number (in_ch.end_of_number),
    .end_of_set    (in_ch.end_of_set),
    .sum_char      (out_ch.sum_char),
    .last_char     (out_ch.last_char),
    .invalid_seen  (out_ch.invalid_seen),
    .overflow      (out_ch.overflow)
  );

endmodule
